>>> design/fcd_pkg.sv
// Package for the FSK correlation demodulator: widths, reset values,
// register indexes and phase constants shared by the interfaces and the RTL.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  // Window and reference table geometry.
  localparam int MAX_TAPS       = 64;
  localparam int TAP_W          = $clog2(MAX_TAPS);
  localparam int LEN_W          = TAP_W + 1;
  localparam int TAP_IDX_W      = 6;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 14;

  // Datapath widths: product, accumulator, shifted correlation and energy.
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + TAP_W;
  localparam int CORR_W = ACC_W - COEF_FRAC_BITS;
  localparam int SQ_W   = 2 * CORR_W;
  localparam int SUM_W  = SQ_W + 1;

  // Configuration register widths and reset values.
  localparam int WL_W         = 7;
  localparam int SHIFT_W      = 4;
  localparam int STEP_W       = 15;
  localparam int NUDGE_W      = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;
  localparam logic [WL_W-1:0]    WL_RESET    = 7'd26;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 15'd2457;
  localparam logic [NUDGE_W-1:0] NUDGE_RESET = 14'd614;

  // Baud phase: a 16-bit fraction of one bit period.
  localparam int PH_W = 16;
  localparam logic [PH_W-1:0] PHASE_HALF = 16'h8000;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_SAMPLE_SHIFT  = 2'd1,
    CFG_BAUD_STEP     = 2'd2,
    CFG_PLL_NUDGE     = 2'd3
  } cfg_reg_e;

  // Item modes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

endpackage

`default_nettype wire

>>> design/fcd_if.sv
// Handshake interfaces of the FSK correlation demodulator: input items,
// result items and configuration writes. Depends on fcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Input items: line samples and reference tap loads.
interface fcd_in_if import fcd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [COEF_W-1:0]    coef_hi_i;
  logic signed [COEF_W-1:0]    coef_hi_q;
  logic signed [COEF_W-1:0]    coef_lo_i;
  logic signed [COEF_W-1:0]    coef_lo_q;

  modport source (
    output valid, mode, sample, tap_index, coef_hi_i, coef_hi_q, coef_lo_i, coef_lo_q,
    input  ready
  );
  modport sink (
    input  valid, mode, sample, tap_index, coef_hi_i, coef_hi_q, coef_lo_i, coef_lo_q,
    output ready
  );
endinterface

// Result items: one recovered bit per transfer.
interface fcd_out_if ();
  logic valid;
  logic ready;
  logic bit_out;

  modport source (output valid, bit_out, input ready);
  modport sink (input valid, bit_out, output ready);
endinterface

// Configuration writes: register index and data.
interface fcd_cfg_if import fcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/fsk_correlation_demodulator.sv
// FSK correlation demodulator: sample window and reference tap memories,
// four-lane correlator, energy compare and baud phase loop.
// Depends on fcd_pkg and the interfaces in fcd_if.sv.
//
// Usage:
//   in_i carries items. A tap load (mode 1) writes one entry of the four
//   reference tables and completes in the cycle of its transfer. A line
//   sample (mode 0) is shifted, written into the window memory, and then
//   correlated against the tables by walking the window memory one tap a
//   cycle, four multiply-accumulate lanes in parallel.
//   A sample occupies the block from its transfer while it reads each window
//   tap of the clamped window length (2 to 64 taps), drains the
//   read/multiply/add pipeline, then squares, sums and takes the
//   decision.
//   in_i.ready is high only while no sample is in progress.
//   out_o carries a recovered bit whenever the baud phase wraps. The bit
//   sits in an output register; a new item is taken while it waits, and a
//   later sample holds in its decision cycle until the register is free.
//   cfg_i is always ready; writes are meant for idle periods.
//   Reset clears the window (through per-entry valid bits), the baud phase,
//   the last decision and restores the register defaults. The reference
//   tables are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module fsk_correlation_demodulator import fcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  fcd_in_if.sink  in_i,
  fcd_out_if.source out_o,
  fcd_cfg_if.sink cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SQUARE,
    ST_SUM,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] hi_i;
    logic signed [COEF_W-1:0] hi_q;
    logic signed [COEF_W-1:0] lo_i;
    logic signed [COEF_W-1:0] lo_q;
  } coef_t;

  // Configuration registers.
  logic [WL_W-1:0]    window_length_q;
  logic [SHIFT_W-1:0] sample_shift_q;
  logic [STEP_W-1:0]  baud_step_q;
  logic [NUDGE_W-1:0] pll_nudge_q;

  // Control state.
  state_e             state_q;
  logic [TAP_W-1:0]   head_q;
  logic [TAP_W-1:0]   pos_q;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   tap_q;
  logic               rd_vld_q;
  logic               prod_vld_q;
  logic               last_dec_q;
  logic [PH_W-1:0]    phase_q;
  logic               out_valid_q;
  logic               bit_out_q;
  logic [MAX_TAPS-1:0] win_vld_q;

  // Memories and datapath registers.
  logic signed [SAMPLE_W-1:0] win_mem [MAX_TAPS];
  coef_t                      coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] win_rd_q;
  logic                       win_rd_vld_q;
  coef_t                      coef_rd_q;
  logic signed [PROD_W-1:0]   prod_q [4];
  logic signed [ACC_W-1:0]    acc_q [4];
  logic [SQ_W-1:0]            sq_q [4];
  logic [SUM_W-1:0]           sum_hi_q;
  logic [SUM_W-1:0]           sum_lo_q;

  // Combinational signals.
  logic                       in_xfer;
  logic                       smp_xfer;
  logic                       coef_xfer;
  logic                       run_issue;
  logic signed [SAMPLE_W-1:0] smp_shifted;
  logic [LEN_W-1:0]           len_clamped;
  logic signed [SAMPLE_W-1:0] win_sample;
  logic signed [COEF_W-1:0]   coef_lane [4];
  logic signed [CORR_W-1:0]   corr [4];
  logic                       decision;
  logic [PH_W-1:0]            phase_adj;
  logic [PH_W:0]              phase_sum;
  logic                       emit;
  logic                       decide_go;

  // Handshakes.
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign smp_xfer    = in_xfer && (in_i.mode == MODE_SAMPLE);
  assign coef_xfer   = in_xfer && (in_i.mode == MODE_COEF)
                       && (32'(in_i.tap_index) < MAX_TAPS);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.bit_out = bit_out_q;

  // Sample scaling and window length clamp.
  assign smp_shifted = in_i.sample >>> sample_shift_q;

  always_comb begin
    if (32'(window_length_q) < 2) begin
      len_clamped = LEN_W'(2);
    end else if (32'(window_length_q) > MAX_TAPS) begin
      len_clamped = LEN_W'(MAX_TAPS);
    end else begin
      len_clamped = LEN_W'(window_length_q);
    end
  end

  assign run_issue = (state_q == ST_RUN);

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WL_RESET;
      sample_shift_q  <= SHIFT_RESET;
      baud_step_q     <= STEP_RESET;
      pll_nudge_q     <= NUDGE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_WINDOW_LENGTH: window_length_q <= cfg_i.data[WL_W-1:0];
        CFG_SAMPLE_SHIFT:  sample_shift_q  <= cfg_i.data[SHIFT_W-1:0];
        CFG_BAUD_STEP:     baud_step_q     <= cfg_i.data[STEP_W-1:0];
        CFG_PLL_NUDGE:     pll_nudge_q     <= cfg_i.data[NUDGE_W-1:0];
      endcase
    end
  end

  // Window memory: written on a sample transfer, read one tap per cycle.
  always_ff @(posedge clk_i) begin
    if (smp_xfer) begin
      win_mem[head_q] <= smp_shifted;
    end
    if (run_issue) begin
      win_rd_q <= win_mem[pos_q];
    end
  end

  // Reference tap memory: written on a tap load, read alongside the window.
  always_ff @(posedge clk_i) begin
    if (coef_xfer) begin
      coef_mem[TAP_W'(in_i.tap_index)] <= '{
        hi_i: in_i.coef_hi_i,
        hi_q: in_i.coef_hi_q,
        lo_i: in_i.coef_lo_i,
        lo_q: in_i.coef_lo_q
      };
    end
    if (run_issue) begin
      coef_rd_q <= coef_mem[tap_q[TAP_W-1:0]];
    end
  end

  // Window entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q    <= '0;
      win_rd_vld_q <= 1'b0;
    end else begin
      if (smp_xfer) begin
        win_vld_q[head_q] <= 1'b1;
      end
      if (run_issue) begin
        win_rd_vld_q <= win_vld_q[pos_q];
      end
    end
  end

  assign win_sample   = win_rd_vld_q ? win_rd_q : '0;
  assign coef_lane[0] = coef_rd_q.hi_i;
  assign coef_lane[1] = coef_rd_q.hi_q;
  assign coef_lane[2] = coef_rd_q.lo_i;
  assign coef_lane[3] = coef_rd_q.lo_q;

  // Each correlation floored to its integer part; it always fits CORR_W bits.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      corr[j] = CORR_W'(acc_q[j] >>> COEF_FRAC_BITS);
    end
  end

  // Four correlator lanes: multiply, then accumulate; then square and sum.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (rd_vld_q) begin
        prod_q[j] <= win_sample * coef_lane[j];
      end
      if (smp_xfer) begin
        acc_q[j] <= '0;
      end else if (prod_vld_q) begin
        acc_q[j] <= acc_q[j] + ACC_W'(prod_q[j]);
      end
      if (state_q == ST_SQUARE) begin
        sq_q[j] <= corr[j] * corr[j];
      end
    end
    if (state_q == ST_SUM) begin
      sum_hi_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]);
      sum_lo_q <= SUM_W'(sq_q[2]) + SUM_W'(sq_q[3]);
    end
  end

  // Decision and baud phase loop.
  assign decision = (sum_hi_q > sum_lo_q);

  always_comb begin
    if (decision != last_dec_q) begin
      if (phase_q < PHASE_HALF) begin
        phase_adj = phase_q + PH_W'(pll_nudge_q);
      end else begin
        phase_adj = phase_q - PH_W'(pll_nudge_q);
      end
    end else begin
      phase_adj = phase_q;
    end
  end

  assign phase_sum = {1'b0, phase_adj} + (PH_W + 1)'(baud_step_q);
  assign emit      = phase_sum[PH_W];
  assign decide_go = (state_q == ST_DECIDE) && (!out_valid_q || out_o.ready);

  // Sequencer with the head, tap counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      tap_q       <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      last_dec_q  <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      bit_out_q   <= 1'b0;
    end else begin
      rd_vld_q   <= run_issue;
      prod_vld_q <= rd_vld_q;

      // The output register empties on a transfer and fills on a wrap.
      if (decide_go && emit) begin
        out_valid_q <= 1'b1;
        bit_out_q   <= decision;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (smp_xfer) begin
            head_q  <= head_q + TAP_W'(1);
            pos_q   <= head_q + TAP_W'(1) - TAP_W'(len_clamped);
            len_q   <= len_clamped;
            tap_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          pos_q <= pos_q + TAP_W'(1);
          tap_q <= tap_q + LEN_W'(1);
          if (tap_q == len_q - LEN_W'(1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_q && !prod_vld_q) begin
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (decide_go) begin
            last_dec_q <= decision;
            phase_q    <= phase_sum[PH_W-1:0];
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
